/* rtl/bors_pkg.sv */
// ----------------------------------------------------------------------------
// bors_pkg
// Types and constants shared by the best-overlap region select unit.
// ----------------------------------------------------------------------------
package bors_pkg;

  localparam int unsigned DEF_MAX_REGIONS = 64;
  localparam int unsigned DEF_COORD_BITS  = 16;

  localparam int unsigned FIELD_W = 16;  // edge field width on the ports
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned CNT_W   = 7;   // region_count register width
  localparam int unsigned AREA_W  = 32;

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [SLOT_W-1:0]  slot;
    logic [FIELD_W-1:0] box_left;
    logic [FIELD_W-1:0] box_top;
    logic [FIELD_W-1:0] box_right;
    logic [FIELD_W-1:0] box_bottom;
    logic               visible;
  } item_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] match_slot;
    logic [AREA_W-1:0] match_area;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // write the region table
    logic capture;  // latch query box, clear best, rewind scan index
    logic issue;    // read the entry at the scan index and advance
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_none;   // accepted query searches no entry
    logic last_issue;  // scan index is at the last searched entry
    logic pipe_empty;  // no entry in flight in the area pipeline
  } sts_t;

endpackage

/* rtl/bors_datapath.sv */
// ----------------------------------------------------------------------------
// bors_datapath
// Region table memory, count register and the shared span/multiply/compare
// pipeline that searches the table for the largest overlap.
// ----------------------------------------------------------------------------
module bors_datapath import bors_pkg::*; #(
  parameter int unsigned MAX_REGIONS = DEF_MAX_REGIONS,
  parameter int unsigned COORD_BITS  = DEF_COORD_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  item_t            item_i,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_data_i,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  output result_t          result_o
);

  localparam int unsigned AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned PW = 2 * COORD_BITS;
  localparam int unsigned EW = 4 * COORD_BITS;

  function automatic logic [CW-1:0] coord(input logic [FIELD_W-1:0] f);
    logic [CW+FIELD_W-1:0] e;
    e = {{CW{1'b0}}, f};
    return e[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] span(input logic [CW-1:0] lo_a, input logic [CW-1:0] hi_a,
                                         input logic [CW-1:0] lo_b, input logic [CW-1:0] hi_b);
    logic [CW-1:0] lo;
    logic [CW-1:0] hi;
    lo = (lo_a > lo_b) ? lo_a : lo_b;
    hi = (hi_a < hi_b) ? hi_a : hi_b;
    return (hi > lo) ? (hi - lo) : '0;
  endfunction

  // Region table
  logic [EW-1:0] mem [MAX_REGIONS];
  logic [EW-1:0] rd_q;

  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] n_q, idx_q;
  logic [CW-1:0]    ql_q, qt_q, qr_q, qb_q;

  logic [SLOT_W-1:0] idx1_q, idx2_q, idx3_q;
  logic              v1_q, v2_q, v3_q;
  logic [CW-1:0]     w_q, h_q;
  logic [PW-1:0]     prod_q, best_q;
  logic [SLOT_W-1:0] best_idx_q;

  logic [AW+SLOT_W-1:0] slot_ext;
  logic [AW+CNT_W-1:0]  idx_ext;
  logic                 slot_ok;
  logic [CW-1:0]        rl, rt, rr, rb;
  logic [PW+AREA_W-1:0] area_ext;

  assign slot_ext = {{AW{1'b0}}, item_i.slot};
  assign idx_ext  = {{AW{1'b0}}, idx_q};
  assign slot_ok  = (32'(item_i.slot) < MAX_REGIONS);
  assign n_eff    = (32'(cnt_q) > MAX_REGIONS) ? CNT_W'(MAX_REGIONS) : cnt_q;

  assign {rl, rt, rr, rb} = rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cfg_we_i) begin
      cnt_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && slot_ok) begin
      mem[slot_ext[AW-1:0]] <= {coord(item_i.box_left), coord(item_i.box_top),
                                coord(item_i.box_right), coord(item_i.box_bottom)};
    end
    if (cmd_i.issue) begin
      rd_q <= mem[idx_ext[AW-1:0]];
    end
  end

  // Query capture and scan index
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ql_q  <= coord(item_i.box_left);
      qt_q  <= coord(item_i.box_top);
      qr_q  <= coord(item_i.box_right);
      qb_q  <= coord(item_i.box_bottom);
      n_q   <= item_i.visible ? n_eff : '0;
      idx_q <= '0;
    end else if (cmd_i.issue) begin
      idx_q <= idx_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage 1: spans; stage 2: product; stage 3: running maximum
  always_ff @(posedge clk_i) begin
    idx1_q <= idx_q[SLOT_W-1:0];
    idx2_q <= idx1_q;
    idx3_q <= idx2_q;
    w_q    <= span(ql_q, qr_q, rl, rr);
    h_q    <= span(qt_q, qb_q, rt, rb);
    prod_q <= PW'(w_q) * PW'(h_q);
    if (cmd_i.capture) begin
      best_q     <= '0;
      best_idx_q <= '0;
    end else if (v3_q && (prod_q > best_q)) begin
      best_q     <= prod_q;
      best_idx_q <= idx3_q;
    end
  end

  assign sts_o.scan_none  = !item_i.visible || (n_eff == '0);
  assign sts_o.last_issue = (idx_q == (n_q - CNT_W'(1)));
  assign sts_o.pipe_empty = !(v1_q || v2_q || v3_q);

  assign area_ext = {{AREA_W{1'b0}}, best_q};

  assign result_o.found      = (best_q != '0);
  assign result_o.match_slot = best_idx_q;
  assign result_o.match_area = (area_ext[PW+AREA_W-1:AREA_W] != '0) ? '1
                                                                     : area_ext[AREA_W-1:0];

endmodule

/* rtl/bors_ctrl.sv */
// ----------------------------------------------------------------------------
// bors_ctrl
// Sequencer: takes items, walks the scan, drains the pipeline, reports.
// ----------------------------------------------------------------------------
module bors_ctrl import bors_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  op_e  op_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o,
  output logic done_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_REPORT = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;
  assign done_o = (state_q == S_REPORT);

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (op_i == OP_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.capture = 1'b1;
            state_d       = sts_i.scan_none ? S_REPORT : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd_o.issue = 1'b1;
        if (sts_i.last_issue) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts_i.pipe_empty) begin
          state_d = S_REPORT;
        end
      end
      S_REPORT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/best_overlap_region_select_unit.sv */
// ----------------------------------------------------------------------------
// best_overlap_region_select_unit
// Region table with a best-overlap search for one query box at a time.
// ----------------------------------------------------------------------------
// A load item (op = load) writes one region box into the table and busy
// stays low. A query item raises busy and searches the first
// min(region_count, MAX_REGIONS) entries through one shared span, multiply
// and compare pipeline fed by the table's single read port, one entry per
// cycle; an invisible query or a zero count searches no entry. The
// result is shown for exactly one cycle with done high, the last busy cycle;
// it is not held, so capture it then. Configuration is taken while idle.
// ----------------------------------------------------------------------------
module best_overlap_region_select_unit import bors_pkg::*; #(
  parameter int unsigned MAX_REGIONS = DEF_MAX_REGIONS,
  parameter int unsigned COORD_BITS  = DEF_COORD_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // item channel
  input  logic             start,
  output logic             busy,
  input  item_t            item_i,
  // result channel
  output logic             done_o,
  output result_t          result_o,
  // region_count write channel
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CNT_W-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // Hold off configuration while a query is in flight.
  assign cfg_ready_o = !busy;

  bors_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .op_i   (item_i.op),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy),
    .done_o (done_o)
  );

  bors_datapath #(
    .MAX_REGIONS(MAX_REGIONS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item_i),
    .cfg_we_i  (cfg_valid_i && cfg_ready_o),
    .cfg_data_i(cfg_data_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .result_o  (result_o)
  );

  // An accepted query always raises busy.
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.op == OP_QUERY) |=> busy)
    else $error("query accepted without raising busy");

  // Loads never occupy the block.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.op == OP_LOAD) |=> !busy)
    else $error("load raised busy");

  // The result cycle ends the item.
  a_done_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!busy && !done_o))
    else $error("busy held after result");

  // An empty result reports index and area as zero.
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.found) |-> (result_o.match_slot == '0 && result_o.match_area == '0))
    else $error("nonzero fields without a match");

endmodule
